[hdl/mlp_pkg.sv]
package mlp_pkg;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_PIXEL  = 2'd1,
    REQ_RUN    = 2'd2
  } req_code_t;

  localparam int REQ_W    = 2;
  localparam int INDEX_W  = 14;
  localparam int WEIGHT_W = 16;
  localparam int PIXEL_W  = 8;
  localparam int DIGIT_W  = 4;
  localparam int ACT_W    = 16;

  localparam int ACC_W  = 48;
  localparam int PROD_W = ACT_W + 1 + WEIGHT_W;

  localparam int L1_SHIFT  = 14;
  localparam int HID_SHIFT = 22;

  localparam logic signed [ACC_W-1:0] Q6_LO = -48'sd512;
  localparam logic signed [ACC_W-1:0] Q6_HI = 48'sd511;

  localparam int ROM_DEPTH = 1024;
  localparam int ROM_AW    = 10;
  localparam int ROM_HALF  = 512;

  localparam logic [31:0] EXP_STEP  = 32'd4228380000;
  localparam int          DIV_STEPS = 17;

endpackage

[hdl/mlp_req_if.sv]
interface mlp_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [mlp_pkg::REQ_W-1:0]             req_type;
  logic [mlp_pkg::INDEX_W-1:0]           index;
  logic signed [mlp_pkg::WEIGHT_W-1:0]   weight_value;
  logic [mlp_pkg::PIXEL_W-1:0]           pixel_value;

  modport source(output valid, req_type, index, weight_value, pixel_value, input ready);
  modport sink(input valid, req_type, index, weight_value, pixel_value, output ready);
endinterface

[hdl/mlp_res_if.sv]
interface mlp_res_if;
  logic                          valid;
  logic                          ready;
  logic [mlp_pkg::DIGIT_W-1:0]   digit;
  logic [mlp_pkg::ACT_W-1:0]     activation;
  logic                          last;

  modport source(output valid, digit, activation, last, input ready);
  modport sink(input valid, digit, activation, last, output ready);
endinterface

[hdl/mlp_ram.sv]
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mlp_inference_sigmoid.sv]
// weight and pixel writes: one beat per cycle while idle, written in the cycle they are accepted
// run: each layer is computed one neuron at a time by the single mac, which
//   walks the weight memory one word a cycle while accumulating
// results: N_OUTPUTS beats (ten by default), one per output neuron, held in an output register
// after reset the sigmoid memory is built by a shift-subtract divider;
//   no request is accepted until it finishes
module mlp_inference_sigmoid #(
  parameter int N_INPUTS        = 784,
  parameter int N_FIRST_HIDDEN  = 16,
  parameter int N_SECOND_HIDDEN = 16,
  parameter int N_OUTPUTS       = 10
) (
  input  logic      clk,
  input  logic      rst,
  mlp_req_if.sink   req,
  mlp_res_if.source res
);

  localparam int L2_BASE = N_INPUTS * N_FIRST_HIDDEN;
  localparam int L3_BASE = L2_BASE + N_FIRST_HIDDEN * N_SECOND_HIDDEN;
  localparam int W_DEPTH = L3_BASE + N_SECOND_HIDDEN * N_OUTPUTS;
  localparam int WAW     = $clog2(W_DEPTH);
  localparam int PAW     = N_INPUTS > 1 ? $clog2(N_INPUTS) : 1;
  localparam int A_DEPTH = N_FIRST_HIDDEN + N_SECOND_HIDDEN;
  localparam int AAW     = $clog2(A_DEPTH);
  localparam int MAX_A   = N_INPUTS > N_FIRST_HIDDEN ? N_INPUTS : N_FIRST_HIDDEN;
  localparam int MAX_B   = N_SECOND_HIDDEN > N_OUTPUTS ? N_SECOND_HIDDEN : N_OUTPUTS;
  localparam int MAXN    = MAX_A > MAX_B ? MAX_A : MAX_B;
  localparam int CW      = $clog2(MAXN + 1);

  typedef enum logic [3:0] {
    S_INIT_START,
    S_DIV,
    S_WROM,
    S_MUL,
    S_EXP,
    S_IDLE,
    S_MAC,
    S_ACT,
    S_ROM,
    S_SIG
  } state_t;

  typedef enum logic [1:0] {
    LAY_FIRST,
    LAY_SECOND,
    LAY_OUT
  } layer_t;

  state_t state;
  layer_t lay;

  // rom build
  logic [32:0] ex;
  logic [9:0]  x;
  logic [63:0] eprod;
  logic [33:0] d;
  logic [33:0] rem;
  logic [16:0] nlo;
  logic [16:0] q;
  logic [4:0]  dcnt;
  logic        part;

  logic [33:0] dd;
  logic [32:0] dh;
  logic [48:0] num_v1;
  logic [48:0] num_v2;
  logic [34:0] dt;

  // run
  logic [CW-1:0]  i;
  logic [CW-1:0]  j;
  logic [WAW-1:0] waddr;
  logic           rd_v;
  logic           prod_v;
  logic signed [mlp_pkg::PROD_W-1:0] prod;
  logic signed [mlp_pkg::ACC_W-1:0]  acc;
  logic signed [mlp_pkg::ACC_W-1:0]  sh;
  logic [mlp_pkg::ROM_AW-1:0]        idx;

  logic [CW-1:0]  n_src;
  logic [CW-1:0]  n_dst;
  logic [WAW-1:0] w_base;
  logic [WAW-1:0] next_base;
  logic           issue;
  logic           req_acc;
  logic [mlp_pkg::ACT_W-1:0] src;

  // output register
  logic                          out_valid;
  logic [mlp_pkg::DIGIT_W-1:0]   out_digit;
  logic [mlp_pkg::ACT_W-1:0]     out_act;
  logic                          out_last;

  // memory ports
  logic                            w_we;
  logic [WAW-1:0]                  w_waddr;
  logic [mlp_pkg::WEIGHT_W-1:0]    w_rdata;
  logic                            p_we;
  logic [PAW-1:0]                  p_waddr;
  logic [PAW-1:0]                  p_raddr;
  logic [mlp_pkg::PIXEL_W-1:0]     p_rdata;
  logic                            a_we;
  logic [AAW-1:0]                  a_waddr;
  logic [AAW-1:0]                  a_raddr;
  logic [mlp_pkg::ACT_W-1:0]       a_rdata;
  logic                            r_we;
  logic [mlp_pkg::ROM_AW-1:0]      r_waddr;
  logic [mlp_pkg::ACT_W-1:0]       r_wdata;
  logic [mlp_pkg::ACT_W-1:0]       r_rdata;

  assign req.ready      = (state == S_IDLE);
  assign req_acc        = req.valid && req.ready;
  assign res.valid      = out_valid;
  assign res.digit      = out_digit;
  assign res.activation = out_act;
  assign res.last       = out_last;

  always_comb begin
    case (lay)
      LAY_FIRST: begin
        n_src     = CW'(N_INPUTS);
        n_dst     = CW'(N_FIRST_HIDDEN);
        w_base    = '0;
        next_base = WAW'(L2_BASE);
      end
      LAY_SECOND: begin
        n_src     = CW'(N_FIRST_HIDDEN);
        n_dst     = CW'(N_SECOND_HIDDEN);
        w_base    = WAW'(L2_BASE);
        next_base = WAW'(L3_BASE);
      end
      default: begin
        n_src     = CW'(N_SECOND_HIDDEN);
        n_dst     = CW'(N_OUTPUTS);
        w_base    = WAW'(L3_BASE);
        next_base = WAW'(L3_BASE);
      end
    endcase
  end

  // divider operands: d = 2^32 + e, rounding by d/2
  always_comb begin
    dd     = 34'(64'h1_0000_0000) + 34'(ex);
    dh     = dd[33:1];
    num_v1 = (49'd1 << 48) + 49'(dh);
    num_v2 = {ex, 16'b0} + 49'(dh);
    dt     = {rem, nlo[16]};
  end

  // floor rescale to q.6; the clamp is applied in S_ACT
  always_comb begin
    if (lay == LAY_FIRST) begin
      sh = acc >>> mlp_pkg::L1_SHIFT;
    end else begin
      sh = acc >>> mlp_pkg::HID_SHIFT;
    end
  end

  assign issue   = (state == S_MAC) && (j != n_src);
  assign src     = (lay == LAY_FIRST) ? {{(mlp_pkg::ACT_W - mlp_pkg::PIXEL_W){1'b0}}, p_rdata}
                                      : a_rdata;

  assign w_we    = req_acc && (req.req_type == mlp_pkg::REQ_WEIGHT)
                   && (32'(req.index) < 32'(W_DEPTH));
  assign w_waddr = WAW'(req.index);
  assign p_we    = req_acc && (req.req_type == mlp_pkg::REQ_PIXEL)
                   && (32'(req.index) < 32'(N_INPUTS));
  assign p_waddr = PAW'(req.index);
  assign p_raddr = PAW'(j);

  assign a_we    = (state == S_SIG) && (lay != LAY_OUT);
  assign a_waddr = (lay == LAY_FIRST) ? AAW'(i) : AAW'(i) + AAW'(N_FIRST_HIDDEN);
  assign a_raddr = (lay == LAY_SECOND) ? AAW'(j) : AAW'(j) + AAW'(N_FIRST_HIDDEN);

  assign r_we    = (state == S_WROM);
  assign r_waddr = part ? mlp_pkg::ROM_AW'(mlp_pkg::ROM_HALF) - x
                        : mlp_pkg::ROM_AW'(mlp_pkg::ROM_HALF) + x;
  assign r_wdata = q[16] ? '1 : q[15:0];

  mlp_ram #(.WIDTH(mlp_pkg::WEIGHT_W), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (req.weight_value),
    .raddr (waddr),
    .rdata (w_rdata)
  );

  mlp_ram #(.WIDTH(mlp_pkg::PIXEL_W), .DEPTH(N_INPUTS)) u_pixel_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (req.pixel_value),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  mlp_ram #(.WIDTH(mlp_pkg::ACT_W), .DEPTH(A_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (r_rdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mlp_ram #(.WIDTH(mlp_pkg::ACT_W), .DEPTH(mlp_pkg::ROM_DEPTH)) u_sig_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (idx),
    .rdata (r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT_START;
      lay       <= LAY_FIRST;
      ex        <= 33'h1_0000_0000;
      x         <= '0;
      rd_v      <= 1'b0;
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // mac pipeline
      rd_v   <= issue;
      prod_v <= rd_v;
      prod   <= $signed({1'b0, src}) * $signed(w_rdata);
      if (prod_v) begin
        acc <= acc + mlp_pkg::ACC_W'(prod);
      end
      if (issue) begin
        j     <= j + CW'(1);
        waddr <= waddr + WAW'(n_dst);
      end

      if (res.valid && res.ready && !((state == S_SIG) && (lay == LAY_OUT))) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT_START: begin
          d    <= dd;
          q    <= '0;
          dcnt <= '0;
          if (x != 10'(mlp_pkg::ROM_HALF)) begin
            part <= 1'b0;
            rem  <= 34'(num_v1[48:17]);
            nlo  <= num_v1[16:0];
          end else begin
            part <= 1'b1;
            rem  <= 34'(num_v2[48:17]);
            nlo  <= num_v2[16:0];
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (dt >= {1'b0, d}) begin
            rem <= 34'(dt - {1'b0, d});
            q   <= {q[15:0], 1'b1};
          end else begin
            rem <= dt[33:0];
            q   <= {q[15:0], 1'b0};
          end
          nlo  <= {nlo[15:0], 1'b0};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'(mlp_pkg::DIV_STEPS - 1)) begin
            state <= S_WROM;
          end
        end
        S_WROM: begin
          if (!part && (x != '0)) begin
            part  <= 1'b1;
            rem   <= 34'(num_v2[48:17]);
            nlo   <= num_v2[16:0];
            q     <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else if (x == 10'(mlp_pkg::ROM_HALF)) begin
            state <= S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          eprod <= 64'(ex[31:0]) * 64'(mlp_pkg::EXP_STEP);
          state <= S_EXP;
        end
        S_EXP: begin
          if (x == '0) begin
            ex <= 33'(mlp_pkg::EXP_STEP);
          end else begin
            ex <= 33'((eprod + 64'h8000_0000) >> 32);
          end
          x     <= x + 10'd1;
          state <= S_INIT_START;
        end
        S_IDLE: begin
          if (req_acc && (req.req_type == mlp_pkg::REQ_RUN)) begin
            lay   <= LAY_FIRST;
            i     <= '0;
            j     <= '0;
            waddr <= '0;
            acc   <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if ((j == n_src) && !rd_v && !prod_v) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (sh < mlp_pkg::Q6_LO) begin
            idx <= '0;
          end else if (sh > mlp_pkg::Q6_HI) begin
            idx <= '1;
          end else begin
            idx <= sh[mlp_pkg::ROM_AW-1:0] ^ mlp_pkg::ROM_AW'(mlp_pkg::ROM_HALF);
          end
          state <= S_ROM;
        end
        S_ROM: begin
          state <= S_SIG;
        end
        S_SIG: begin
          if ((lay != LAY_OUT) || !out_valid || res.ready) begin
            if (lay == LAY_OUT) begin
              out_valid <= 1'b1;
              out_digit <= mlp_pkg::DIGIT_W'(i);
              out_act   <= r_rdata;
              out_last  <= (i == n_dst - CW'(1));
            end
            j   <= '0;
            acc <= '0;
            if (i == n_dst - CW'(1)) begin
              i <= '0;
              if (lay == LAY_OUT) begin
                state <= S_IDLE;
              end else begin
                lay   <= (lay == LAY_FIRST) ? LAY_SECOND : LAY_OUT;
                waddr <= next_base;
                state <= S_MAC;
              end
            end else begin
              i     <= i + CW'(1);
              waddr <= w_base + WAW'(i) + WAW'(1);
              state <= S_MAC;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT) |-> (!rd_v && !prod_v))
    else $error("activation taken before mac pipeline drained");

  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last) |-> (res.digit == mlp_pkg::DIGIT_W'(N_OUTPUTS - 1)))
    else $error("last beat not on final output neuron");

  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    (w_we || p_we) |-> (state == S_IDLE))
    else $error("store write outside idle");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == S_SIG) && ($past(lay) == LAY_OUT))
    else $error("result beat raised outside output layer");

endmodule
